/* rtl/core/multi_slot_repeat_timer_unit_assert.svh */
// Assertion macros for the port-level checker file.
`ifndef MULTI_SLOT_REPEAT_TIMER_UNIT_ASSERT_SVH
`define MULTI_SLOT_REPEAT_TIMER_UNIT_ASSERT_SVH
// Overlapping implication, disabled during reset.
`define MST_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked during reset too.
`define MST_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/core/mst_pkg.sv */
// Package with request codes, event codes and the cell control types.
`timescale 1ns / 1ps
package mst_pkg;
  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_CREATE  = 3'd1,
    REQ_DESTROY = 3'd2,
    REQ_PAUSE   = 3'd3,
    REQ_CLEAR   = 3'd4,
    REQ_QUERY   = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    EVT_FIRE     = 2'd0,
    EVT_COMPLETE = 2'd1,
    EVT_OK       = 2'd2,
    EVT_FAIL     = 2'd3
  } kind_t;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_BITS    = 5;

  // Request broadcast to every cell for one cycle.
  typedef struct packed {
    logic        valid;
    req_t        op;
    logic [2:0]  slot;
    logic [15:0] reps;
    logic [31:0] delay;
    logic        pause;
  } cmd_t;

  // Scan control shared by the cells of the chain.
  typedef struct packed {
    logic start;
    logic adv;
    logic stop;
    logic fire;
  } scan_t;

  // Status that one cell reports back.
  typedef struct packed {
    logic used;
    logic due_hit;
    logic last_hit;
  } stat_t;
endpackage

/* rtl/core/mst_req_if.sv */
// Request channel interface.
`timescale 1ns / 1ps
interface mst_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [2:0]  slot;
  logic [15:0] repeat_count;
  logic [31:0] delay_ms;
  logic        pause_flag;
  modport source (output valid, req_type, slot, repeat_count, delay_ms, pause_flag,
                  input ready);
  modport sink (input valid, req_type, slot, repeat_count, delay_ms, pause_flag,
                output ready);
endinterface

/* rtl/core/mst_evt_if.sv */
// Event channel interface.
`timescale 1ns / 1ps
interface mst_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [2:0] event_slot;
  logic       last_event;
  modport source (output valid, event_kind, event_slot, last_event, input ready);
  modport sink (input valid, event_kind, event_slot, last_event, output ready);
endinterface

/* rtl/core/mst_cell.sv */
// One timer slot cell; the scan token passes from cell to cell.
`timescale 1ns / 1ps
module mst_cell #(
  parameter int TIME_BITS = 48,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [TIME_BITS-1:0] now,
  input  mst_pkg::cmd_t        cmd,
  input  mst_pkg::scan_t       scan,
  input  logic                 tok_prev,
  output logic                 tok,
  output mst_pkg::stat_t       stat
);
  import mst_pkg::*;

  logic                 used;
  logic                 paused;
  logic                 forever_rep;
  logic [31:0]          interval;
  logic [15:0]          limit;
  logic [15:0]          fired;
  logic [TIME_BITS-1:0] due;
  logic [TIME_BITS-1:0] pstart;

  logic                 sel;
  logic [15:0]          fired_inc;
  logic                 is_last;
  logic [TIME_BITS:0]   sum_a;
  logic [TIME_BITS:0]   sum_b;
  logic [TIME_BITS:0]   sum_c;
  logic [TIME_BITS-1:0] span;

  assign sel       = (32'(cmd.slot) == IDX);
  assign fired_inc = fired + 16'd1;
  assign is_last   = !forever_rep && (fired_inc >= limit);
  assign span      = now - pstart;
  assign sum_a     = {1'b0, now} + (TIME_BITS+1)'(cmd.delay);
  assign sum_b     = {1'b0, now} + (TIME_BITS+1)'(interval);
  assign sum_c     = {1'b0, due} + {1'b0, span};

  assign stat.used     = used;
  assign stat.due_hit  = tok && used && !paused && (now >= due);
  assign stat.last_hit = tok && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= 1'b0;
      paused <= 1'b0;
      tok    <= 1'b0;
    end else begin
      if (scan.start) begin
        tok <= (IDX == 0);
      end else if (scan.stop) begin
        tok <= 1'b0;
      end else if (scan.adv) begin
        tok <= tok_prev;
      end
      if (scan.fire && tok) begin
        if (!forever_rep) begin
          fired <= fired_inc;
        end
        if (is_last) begin
          used   <= 1'b0;
          paused <= 1'b0;
        end else begin
          due <= sum_b[TIME_BITS] ? '1 : sum_b[TIME_BITS-1:0];
        end
      end
      if (cmd.valid) begin
        case (cmd.op)
          REQ_CREATE: begin
            if (sel && !used) begin
              used        <= 1'b1;
              paused      <= 1'b0;
              forever_rep <= (cmd.reps == 16'd0);
              interval    <= cmd.delay;
              limit       <= cmd.reps;
              fired       <= 16'd0;
              due         <= sum_a[TIME_BITS] ? '1 : sum_a[TIME_BITS-1:0];
            end
          end
          REQ_DESTROY: begin
            if (sel && used) begin
              used   <= 1'b0;
              paused <= 1'b0;
            end
          end
          REQ_PAUSE: begin
            if (sel && used) begin
              if (cmd.pause) begin
                paused <= 1'b1;
                pstart <= now;
              end else if (paused) begin
                due    <= sum_c[TIME_BITS] ? '1 : sum_c[TIME_BITS-1:0];
                paused <= 1'b0;
              end
            end
          end
          REQ_CLEAR: begin
            used   <= 1'b0;
            paused <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end
endmodule

/* rtl/core/multi_slot_repeat_timer_unit.sv */
// Top level of the multi-slot repeating timer bank.
// Channels: req (sink) carries ticks and slot requests, evt (source) carries
// fire, complete and acknowledgement beats; a beat moves when valid and ready
// are both high.
// A request other than a tick is answered by one beat, presented in the cycle
// after it is accepted. A tick starts a scan in which a token walks down the
// row of slot cells, one cell per cycle while the receiver does not stall; the
// token stays on a cell for an extra step (ST_COMPL) when its slot completes.
// The final beat of a tick leaves from ST_FLUSH once the scan has stopped, and
// the next request is taken when the bank is back in ST_IDLE.
// The final beat of each request carries last_event; results are held back
// by one beat so that the flag is known when the beat leaves.
// A tick gives at most sixteen beats; slots that do not fit stay due.
// Reset (synchronous, active high) frees every slot and zeroes the clock.
// When the receiver stalls, the scan waits on the output register and no new
// request is taken until the current one has been fully delivered.
`timescale 1ns / 1ps
module multi_slot_repeat_timer_unit #(
  parameter int SLOTS = 8,
  parameter int TIME_BITS = 48
) (
  input logic clk,
  input logic rst,
  mst_req_if.sink   req,
  mst_evt_if.source evt
);
  import mst_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMPL, ST_FLUSH} state_t;

  state_t               state;
  logic [TIME_BITS-1:0] now;
  logic [IDX_W-1:0]     scan_idx;
  logic [CNT_BITS-1:0]  n_res;
  logic                 hold_valid;
  kind_t                hold_kind;
  logic [2:0]           hold_slot;
  logic                 out_valid;
  kind_t                out_kind;
  logic [2:0]           out_slot;
  logic                 out_last;

  cmd_t                 cmd;
  scan_t                scan;
  stat_t                stat [SLOTS];
  logic [SLOTS:0]       tok_chain;
  logic                 any_due;
  logic                 any_last;
  logic                 used_sel;
  logic                 out_free;
  logic                 at_end;
  logic [CNT_BITS:0]    n_need;
  req_t                 op;

  assign out_free       = !out_valid || evt.ready;
  assign req.ready      = (state == ST_IDLE) && out_free;
  assign evt.valid      = out_valid;
  assign evt.event_kind = out_kind;
  assign evt.event_slot = out_slot;
  assign evt.last_event = out_last;
  assign at_end         = (scan_idx == IDX_W'(SLOTS - 1));
  assign op             = req_t'(req.req_type);
  assign n_need = {1'b0, n_res} + (any_last ? (CNT_BITS+1)'(2) : (CNT_BITS+1)'(1));

  assign cmd.valid = req.valid && req.ready;
  assign cmd.op    = op;
  assign cmd.slot  = req.slot;
  assign cmd.reps  = req.repeat_count;
  assign cmd.delay = req.delay_ms;
  assign cmd.pause = req.pause_flag;

  assign tok_chain[0] = 1'b0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    mst_cell #(.TIME_BITS(TIME_BITS), .IDX(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .now      (now),
      .cmd      (cmd),
      .scan     (scan),
      .tok_prev (tok_chain[k]),
      .tok      (tok_chain[k+1]),
      .stat     (stat[k])
    );
  end

  always_comb begin
    any_due  = 1'b0;
    any_last = 1'b0;
    used_sel = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      any_due  = any_due | stat[k].due_hit;
      any_last = any_last | stat[k].last_hit;
      used_sel = used_sel | (stat[k].used && (32'(req.slot) == k));
    end
  end

  // Scan control: only one cell holds the token during a scan.
  always_comb begin
    scan = '0;
    case (state)
      ST_IDLE: scan.start = req.valid && req.ready && (op == REQ_TICK);
      ST_SCAN: begin
        if (!any_due) begin
          scan.adv  = !at_end;
          scan.stop = at_end;
        end else if (out_free) begin
          if (n_need > (CNT_BITS+1)'(MAX_RESULTS)) begin
            scan.stop = 1'b1;
          end else begin
            scan.fire = 1'b1;
            if (!any_last) begin
              scan.adv  = !at_end;
              scan.stop = at_end;
            end
          end
        end
      end
      ST_COMPL: begin
        if (out_free) begin
          scan.adv  = !at_end;
          scan.stop = at_end;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      now        <= '0;
      scan_idx   <= '0;
      n_res      <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && evt.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid && req.ready) begin
            out_last <= 1'b1;
            out_slot <= req.slot;
            case (op)
              REQ_TICK: begin
                now      <= now + TIME_BITS'(1);
                scan_idx <= '0;
                n_res    <= '0;
                state    <= ST_SCAN;
              end
              REQ_CREATE, REQ_DESTROY, REQ_PAUSE: begin
                out_valid <= 1'b1;
                if (op == REQ_CREATE) begin
                  out_kind <= (32'(req.slot) < SLOTS && !used_sel) ? EVT_OK : EVT_FAIL;
                end else begin
                  out_kind <= used_sel ? EVT_OK : EVT_FAIL;
                end
              end
              REQ_CLEAR: begin
                out_valid <= 1'b1;
                out_kind  <= EVT_OK;
                out_slot  <= 3'd0;
              end
              REQ_QUERY: begin
                out_valid <= 1'b1;
                out_kind  <= used_sel ? EVT_OK : EVT_FAIL;
              end
              default: begin
                out_valid <= 1'b1;
                out_kind  <= EVT_FAIL;
              end
            endcase
          end
        end
        ST_SCAN, ST_COMPL: begin
          if (scan.fire || (state == ST_COMPL && out_free)) begin
            // Push the new beat into the hold stage; the older one leaves.
            if (hold_valid) begin
              out_valid <= 1'b1;
              out_kind  <= hold_kind;
              out_slot  <= hold_slot;
              out_last  <= 1'b0;
            end
            hold_valid <= 1'b1;
            hold_kind  <= (state == ST_COMPL) ? EVT_COMPLETE : EVT_FIRE;
            hold_slot  <= 3'(scan_idx);
            n_res      <= n_res + CNT_BITS'(1);
          end
          if (scan.stop) begin
            state <= ST_FLUSH;
          end else if (scan.adv) begin
            scan_idx <= scan_idx + IDX_W'(1);
            state    <= ST_SCAN;
          end else if (scan.fire && any_last) begin
            state <= ST_COMPL;
          end
        end
        ST_FLUSH: begin
          if (!hold_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_kind   <= hold_kind;
            out_slot   <= hold_slot;
            out_last   <= 1'b1;
            hold_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/mst_checker.sv */
// Port-level checker for the timer bank, bound to the top level.
`timescale 1ns / 1ps
`include "multi_slot_repeat_timer_unit_assert.svh"
module mst_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic       out_last
);
  import mst_pkg::*;

  `MST_ASSERT_IMPL(a_hold, clk, rst, out_valid && !out_ready, ##1 out_valid && $stable(out_kind), "stalled beat changed")
  `MST_ASSERT_IMPL(a_ack_last, clk, rst, out_valid && (out_kind == EVT_OK || out_kind == EVT_FAIL), out_last, "acknowledgement without last flag")
  `MST_ASSERT_NEXT(a_reset, clk, rst, !out_valid, "beat valid after reset")
  `MST_ASSERT_IMPL(a_no_overlap, clk, rst, in_valid && in_ready, !(out_valid && !out_ready), "request taken while a beat stalls")
endmodule

bind multi_slot_repeat_timer_unit mst_checker u_mst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (evt.valid),
  .out_ready (evt.ready),
  .out_kind  (evt.event_kind),
  .out_last  (evt.last_event)
);

/* tb/mst_timer_checker.sv */
// Checker for the timer bank: predicts the event beats and compares them.
`timescale 1ns / 1ps
module mst_timer_checker
  import mst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mst_req_if   req,
  mst_evt_if   evt,
  output int   errors,
  output int   pending
);
  localparam int NSLOT = 8;
  localparam int TBITS = 48;
  localparam logic [TBITS-1:0] TIME_MAX = '1;

  typedef struct {
    logic [1:0] kind;
    logic [2:0] slot;
    logic       last;
  } timer_evt_t;

  timer_evt_t       evt_q[$];
  logic [TBITS-1:0] clock_ms;
  logic             armed [NSLOT];
  logic             held [NSLOT];
  logic             endless [NSLOT];
  logic [31:0]      period [NSLOT];
  logic [15:0]      quota [NSLOT];
  logic [15:0]      shots [NSLOT];
  logic [TBITS-1:0] due_at [NSLOT];
  logic [TBITS-1:0] held_since [NSLOT];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [TBITS-1:0] add_clamped(logic [TBITS-1:0] a, logic [TBITS:0] b);
    logic [TBITS+1:0] s;
    s = a + b;
    return (s > TIME_MAX) ? TIME_MAX : s[TBITS-1:0];
  endfunction

  task automatic report(string what, int idx, logic [5:0] got, logic [5:0] want);
    errors++;
    if (errors <= 30)
      $display("%0t mismatch in %s of beat %0d: got %0h expected %0h", $time, what, idx, got,
               want);
  endtask

  task automatic push_evt(logic [1:0] kind, logic [2:0] slot);
    timer_evt_t e;
    e.kind = kind;
    e.slot = slot;
    e.last = 1'b0;
    evt_q.push_back(e);
  endtask

  // Advance the clock and fire every due slot in ascending order, within the beat budget.
  task automatic run_tick();
    int  n;
    int  want;
    bool_done:
    begin
    end
    n = 0;
    clock_ms = clock_ms + 1'b1;
    for (int i = 0; i < NSLOT; i++) begin
      logic fin;
      if (!armed[i] || held[i] || clock_ms < due_at[i]) continue;
      fin  = !endless[i] && (16'(shots[i] + 16'd1) >= quota[i]);
      want = fin ? 2 : 1;
      if (n + want > MAX_RESULTS) break;
      push_evt(EVT_FIRE, 3'(i));
      n++;
      if (!endless[i]) shots[i] = shots[i] + 16'd1;
      if (fin) begin
        push_evt(EVT_COMPLETE, 3'(i));
        n++;
        armed[i] = 1'b0;
        held[i]  = 1'b0;
      end else begin
        due_at[i] = add_clamped(clock_ms, {17'd0, period[i]});
      end
    end
    if (n > 0) evt_q[$].last = 1'b1;
  endtask

  task automatic apply_request(logic [2:0] op, logic [2:0] s, logic [15:0] reps,
                               logic [31:0] dly, logic pz);
    logic [1:0] kind;
    logic [2:0] eslot;
    kind  = EVT_FAIL;
    eslot = s;
    case (op)
      REQ_TICK: begin
        run_tick();
        return;
      end
      REQ_CREATE: begin
        if (!armed[s]) begin
          armed[s]      = 1'b1;
          held[s]       = 1'b0;
          endless[s]    = (reps == 16'd0);
          period[s]     = dly;
          quota[s]      = reps;
          shots[s]      = '0;
          due_at[s]     = add_clamped(clock_ms, {17'd0, dly});
          held_since[s] = '0;
          kind          = EVT_OK;
        end
      end
      REQ_DESTROY: begin
        if (armed[s]) begin
          armed[s] = 1'b0;
          held[s]  = 1'b0;
          kind     = EVT_OK;
        end
      end
      REQ_PAUSE: begin
        if (armed[s]) begin
          if (pz) begin
            held[s]       = 1'b1;
            held_since[s] = clock_ms;
          end else if (held[s]) begin
            due_at[s]     = add_clamped(due_at[s], {1'b0, clock_ms - held_since[s]});
            held[s]       = 1'b0;
            held_since[s] = '0;
          end
          kind = EVT_OK;
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) begin
          armed[i] = 1'b0;
          held[i]  = 1'b0;
        end
        kind  = EVT_OK;
        eslot = '0;
      end
      REQ_QUERY: kind = armed[s] ? EVT_OK : EVT_FAIL;
      default: kind = EVT_FAIL;
    endcase
    push_evt(kind, eslot);
    evt_q[$].last = 1'b1;
  endtask

  int beat_no = 0;

  always @(posedge clk) begin
    if (rst) begin
      clock_ms = '0;
      for (int i = 0; i < NSLOT; i++) begin
        armed[i]      = 1'b0;
        held[i]       = 1'b0;
        endless[i]    = 1'b0;
        period[i]     = '0;
        quota[i]      = '0;
        shots[i]      = '0;
        due_at[i]     = '0;
        held_since[i] = '0;
      end
      evt_q.delete();
    end else begin
      if (evt.valid && evt.ready) begin
        if (evt_q.size() == 0) begin
          report("unexpected beat", beat_no, {evt.event_kind, evt.event_slot, evt.last_event},
                 6'd0);
        end else begin
          timer_evt_t e;
          e = evt_q.pop_front();
          if (evt.event_kind !== e.kind) report("event_kind", beat_no, 6'(evt.event_kind), 6'(e.kind));
          if (evt.event_slot !== e.slot) report("event_slot", beat_no, 6'(evt.event_slot), 6'(e.slot));
          if (evt.last_event !== e.last) report("last_event", beat_no, 6'(evt.last_event), 6'(e.last));
        end
        beat_no++;
      end
      if (req.valid && req.ready)
        apply_request(req.req_type, req.slot, req.repeat_count, req.delay_ms, req.pause_flag);
    end
    pending = evt_q.size();
  end
endmodule

/* tb/tb_top.sv */
// Top of the timer bank testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import mst_pkg::*;

  localparam logic [2:0] REQ_BAD_LO = 3'd6;
  localparam logic [2:0] REQ_BAD_HI = 3'd7;

  logic clk;
  logic rst;
  int   errors;
  int   pending;

  mst_req_if req ();
  mst_evt_if evt ();

  multi_slot_repeat_timer_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .evt (evt.source)
  );

  mst_timer_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .evt     (evt),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one request and hold it until the beat is taken.
  task automatic send(logic [2:0] op, logic [2:0] s, logic [15:0] reps, logic [31:0] dly,
                      logic pz);
    req.valid        <= 1'b1;
    req.req_type     <= op;
    req.slot         <= s;
    req.repeat_count <= reps;
    req.delay_ms     <= dly;
    req.pause_flag   <= pz;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic idle_req();
    int n;
    n = gap_len();
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic tick_n(int n);
    repeat (n) begin
      send(REQ_TICK, 3'($urandom), 16'($urandom), $urandom, 1'($urandom));
      idle_req();
    end
  endtask

  // The receiver holds ready high for a while, then stalls for a random gap.
  initial begin
    int n;
    evt.ready = 1'b0;
    @(negedge clk);
    forever begin
      evt.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      n = gap_len();
      if (n > 0) begin
        evt.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin
    int r;
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.req_type     = REQ_TICK;
    req.slot         = '0;
    req.repeat_count = '0;
    req.delay_ms     = '0;
    req.pause_flag   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: limits of the fields, every request and the corner cases.
    send(REQ_CREATE, 3'd0, 16'd1, 32'd0, 1'b0);
    tick_n(1);
    send(REQ_CREATE, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send(REQ_CREATE, 3'd7, 16'd2, 32'd1, 1'b0);
    send(REQ_QUERY, 3'd7, '0, '0, 1'b0);
    send(REQ_QUERY, 3'd3, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send(REQ_PAUSE, 3'd7, '0, '0, 1'b1);
    send(REQ_PAUSE, 3'd7, '0, '0, 1'b1);
    send(REQ_PAUSE, 3'd7, '0, '0, 1'b0);
    send(REQ_PAUSE, 3'd7, '0, '0, 1'b0);
    send(REQ_DESTROY, 3'd7, '0, '0, 1'b0);
    send(REQ_DESTROY, 3'd7, '0, '0, 1'b0);
    send(REQ_PAUSE, 3'd2, '0, '0, 1'b1);
    send(REQ_BAD_LO, 3'd5, '0, '0, 1'b0);
    send(REQ_BAD_HI, 3'd6, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send(REQ_CREATE, 3'd1, 16'd0, 32'd2, 1'b0);
    send(REQ_PAUSE, 3'd1, '0, '0, 1'b1);
    tick_n(3);
    send(REQ_PAUSE, 3'd1, '0, '0, 1'b0);
    tick_n(3);
    send(REQ_CLEAR, 3'd5, '0, '0, 1'b0);
    // Every slot completing on the same tick fills the beat budget exactly.
    for (int i = 0; i < 8; i++) send(REQ_CREATE, 3'(i), 16'd1, 32'd0, 1'b0);
    tick_n(1);

    for (int k = 0; k < 300; k++) begin
      logic [2:0]  op;
      logic [15:0] reps;
      logic [31:0] dly;
      r = $urandom_range(0, 99);
      if (r < 45) op = REQ_TICK;
      else if (r < 70) op = REQ_CREATE;
      else if (r < 77) op = REQ_DESTROY;
      else if (r < 86) op = REQ_PAUSE;
      else if (r < 89) op = REQ_CLEAR;
      else if (r < 97) op = REQ_QUERY;
      else op = (r[0]) ? REQ_BAD_HI : REQ_BAD_LO;
      reps = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4)) : 16'($urandom);
      dly  = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 6)) : $urandom;
      send(op, 3'($urandom), reps, dly, 1'($urandom));
      idle_req();
    end
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
